[hdl/rgb_to_hsv_pixel_core_macros.svh]
// assertion macros shared by the rgb to hsv pixel core
`ifndef RGB_TO_HSV_PIXEL_CORE_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define RTH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rgb_to_hsv_pixel_core: check failed");

// consequent checked in the cycle after the antecedent
`define RTH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_to_hsv_pixel_core: check failed");

`else

`define RTH_ASSERT(lbl, prop)
`define RTH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/rth_pkg.sv]
// types and constants of the rgb to hsv pixel core
package rth_pkg;

	// input pixel request
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	// converted pixel request
	typedef struct packed {
		logic [7:0] hue_half_degrees;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	// hue sector bases in half degrees
	localparam logic [7:0] HUE_BASE_RED   = 8'd0;
	localparam logic [7:0] HUE_BASE_GREEN = 8'd60;
	localparam logic [7:0] HUE_BASE_BLUE  = 8'd120;
	localparam logic [7:0] HUE_BASE_WRAP  = 8'd180;

	// divider shapes: 255*chroma/max and 30*diff/chroma
	localparam int SAT_NUM_W = 16;
	localparam int SAT_QUO_W = 8;
	localparam int HUE_NUM_W = 13;
	localparam int HUE_QUO_W = 5;

	// default number of divider pipeline stages
	localparam int RTH_DIV_STAGES = 4;

	// per-pixel data that rides alongside the dividers
	typedef struct packed {
		logic [7:0] brightness;
		logic [7:0] base;
		logic       neg;
		logic       gray;
		logic       black;
	} side_t;

endpackage

[hdl/rth_div_pipe.sv]
// pipelined restoring divider, ceil(QUO_W/STAGES) quotient bits per stage
module rth_div_pipe import rth_pkg::*; #(
	parameter int NUM_W  = SAT_NUM_W,
	parameter int DEN_W  = 8,
	parameter int QUO_W  = SAT_QUO_W,
	parameter int STAGES = RTH_DIV_STAGES
) (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [QUO_W-1:0]  quo,
	output logic              rem_nz
);

	// quotient bits resolved per stage
	localparam int STEP_N = (QUO_W + STAGES - 1) / STAGES;
	// room for the divisor shifted up by the top quotient bit
	localparam int WIDE_W = NUM_W + DEN_W;

	logic [NUM_W-1:0] rem_s [STAGES];
	logic [DEN_W-1:0] den_s [STAGES];
	logic [QUO_W-1:0] quo_s [STAGES];

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		logic [NUM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [QUO_W-1:0]  quo_in;
		logic [NUM_W-1:0]  rem_nx;
		logic [QUO_W-1:0]  quo_nx;
		logic [WIDE_W-1:0] dsh;

		// previous stage, or the request itself at the head
		if (s == 0) begin : g_head
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_body
			assign rem_in = rem_s[s-1];
			assign den_in = den_s[s-1];
			assign quo_in = quo_s[s-1];
		end

		// compare and subtract, msb of quotient first
		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			dsh    = '0;
			for (int j = 0; j < STEP_N; j++) begin
				if (s * STEP_N + j < QUO_W) begin
					dsh = {{NUM_W{1'b0}}, den_in} << (QUO_W - 1 - (s * STEP_N + j));
					if ({{DEN_W{1'b0}}, rem_nx} >= dsh) begin
						rem_nx = rem_nx - dsh[NUM_W-1:0];
						quo_nx = quo_nx | (QUO_W'(1) << (QUO_W - 1 - (s * STEP_N + j)));
					end
				end
			end
		end

		// stage register
		always_ff @(posedge clk) begin
			if (en[s]) begin
				rem_s[s] <= rem_nx;
				den_s[s] <= den_in;
				quo_s[s] <= quo_nx;
			end
		end
	end

	assign quo    = quo_s[STAGES-1];
	assign rem_nz = |rem_s[STAGES-1];

endmodule

[hdl/rgb_to_hsv_pixel_core.sv]
// rgb to hsv pixel converter, top level
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   pix     | pix_valid / pix_ready  | pix_t: blue, green, red
//   hsv     | hsv_valid / hsv_ready  | hsv_t: hue_half_degrees, saturation,
//           |                        |        brightness
//
// one pixel per cycle sustained while hsv_ready stays high; stages are the min/max
// stage, numerator stage, the divider stages and the output register
// each stage has its own valid bit and takes a new request when it is empty or
// its successor moves, so bubbles close up and stalls lose nothing
// reset clears only the valid bits; no clearing pass is needed
`include "rgb_to_hsv_pixel_core_macros.svh"

module rgb_to_hsv_pixel_core import rth_pkg::*; #(
	parameter int DIV_STAGES = RTH_DIV_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_ready,
	input  pix_t pix,
	output logic hsv_valid,
	input  logic hsv_ready,
	output hsv_t hsv
);

	// min/max stage, numerator stage, divider stages, output stage
	localparam int STG_N = DIV_STAGES + 3;

	logic [STG_N-1:0] vld_s;
	logic [STG_N:0]   rdy;

	// stage flow control
	always_comb begin
		rdy[STG_N] = hsv_ready;
		for (int k = STG_N - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < STG_N; k++) begin
				if (rdy[k]) begin
					if (k == 0) begin
						vld_s[k] <= pix_valid;
					end else begin
						vld_s[k] <= vld_s[k-1];
					end
				end
			end
		end
	end

	assign pix_ready = rdy[0];
	assign hsv_valid = vld_s[STG_N-1];

	// stage 1: max, min, chroma and hue sector
	logic [7:0] mx;
	logic [7:0] mn;
	logic [7:0] dif;
	logic [7:0] base;
	logic       neg;

	always_comb begin
		mx = pix.red;
		mn = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		if (mx == pix.red) begin
			neg  = pix.green < pix.blue;
			dif  = neg ? pix.blue - pix.green : pix.green - pix.blue;
			base = neg ? HUE_BASE_WRAP : HUE_BASE_RED;
		end else if (mx == pix.green) begin
			neg  = pix.blue < pix.red;
			dif  = neg ? pix.red - pix.blue : pix.blue - pix.red;
			base = HUE_BASE_GREEN;
		end else begin
			neg  = pix.red < pix.green;
			dif  = neg ? pix.green - pix.red : pix.red - pix.green;
			base = HUE_BASE_BLUE;
		end
	end

	logic [7:0] mx_s1;
	logic [7:0] c_s1;
	logic [7:0] dif_s1;
	logic [7:0] base_s1;
	logic       neg_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			mx_s1   <= mx;
			c_s1    <= mx - mn;
			dif_s1  <= dif;
			base_s1 <= base;
			neg_s1  <= neg;
		end
	end

	// stage 2: divider numerators 255*chroma and 30*diff
	logic [SAT_NUM_W-1:0] sat_num_s2;
	logic [HUE_NUM_W-1:0] hue_num_s2;
	logic [7:0]           mx_s2;
	logic [7:0]           c_s2;
	side_t                side_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			sat_num_s2 <= {c_s1, 8'h00} - {8'h00, c_s1};
			hue_num_s2 <= ({5'd0, dif_s1} << 5) - ({5'd0, dif_s1} << 1);
			mx_s2      <= mx_s1;
			c_s2       <= c_s1;
			side_s2    <= '{brightness: mx_s1, base: base_s1, neg: neg_s1,
				gray: (c_s1 == 8'd0), black: (mx_s1 == 8'd0)};
		end
	end

	// divider stages
	logic [SAT_QUO_W-1:0] sat_quo;
	logic [HUE_QUO_W-1:0] hue_quo;
	logic                 sat_nz;
	logic                 hue_nz;

	rth_div_pipe #(
		.NUM_W  (SAT_NUM_W),
		.DEN_W  (8),
		.QUO_W  (SAT_QUO_W),
		.STAGES (DIV_STAGES)
	) u_sat_div (
		.clk    (clk),
		.en     (rdy[2 +: DIV_STAGES]),
		.num    (sat_num_s2),
		.den    (mx_s2),
		.quo    (sat_quo),
		.rem_nz (sat_nz)
	);

	rth_div_pipe #(
		.NUM_W  (HUE_NUM_W),
		.DEN_W  (8),
		.QUO_W  (HUE_QUO_W),
		.STAGES (DIV_STAGES)
	) u_hue_div (
		.clk    (clk),
		.en     (rdy[2 +: DIV_STAGES]),
		.num    (hue_num_s2),
		.den    (c_s2),
		.quo    (hue_quo),
		.rem_nz (hue_nz)
	);

	// side data follows the divider stages
	side_t side_sd [DIV_STAGES];

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (rdy[2+k]) begin
				if (k == 0) begin
					side_sd[k] <= side_s2;
				end else begin
					side_sd[k] <= side_sd[k-1];
				end
			end
		end
	end

	// output stage: apply sector base, round negative offsets up, zero hue for gray and saturation for black
	side_t      side_last;
	logic [7:0] hue_off;
	hsv_t       hsv_nx;
	hsv_t       hsv_so;

	assign side_last = side_sd[DIV_STAGES-1];
	assign hue_off   = {3'd0, hue_quo};

	always_comb begin
		hsv_nx.brightness = side_last.brightness;
		hsv_nx.saturation = side_last.black ? 8'd0 : sat_quo;
		if (side_last.gray) begin
			hsv_nx.hue_half_degrees = 8'd0;
		end else if (side_last.neg) begin
			hsv_nx.hue_half_degrees = side_last.base - hue_off - {7'd0, hue_nz};
		end else begin
			hsv_nx.hue_half_degrees = side_last.base + hue_off;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[STG_N-1]) begin
			hsv_so <= hsv_nx;
		end
	end

	assign hsv = hsv_so;

	// checks
	`RTH_ASSERT(a_hue_range, hsv_valid |-> (hsv.hue_half_degrees < 8'd180))
	`RTH_ASSERT(a_gray_hue, (hsv_valid && hsv.saturation == 8'd0) |-> (hsv.hue_half_degrees == 8'd0))
	`RTH_ASSERT(a_black_sat, (hsv_valid && hsv.brightness == 8'd0) |-> (hsv.saturation == 8'd0))
	`RTH_ASSERT(a_gray_sat_exact, (vld_s[STG_N-2] && side_last.gray) |-> !sat_nz)
	`RTH_ASSERT_NEXT(a_s1_hold, vld_s[0] && !rdy[0], vld_s[0])
	`RTH_ASSERT_NEXT(a_out_load, vld_s[STG_N-2] && rdy[STG_N-1], hsv_valid)

endmodule

[tb/rgb_to_hsv_pixel_core_test.sv]
// self-checking testbench of the rgb to hsv pixel core with random stalls on both channels
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_core_test;
	import rth_pkg::*;

	// cycles of quiet that end the run as hung
	localparam int WATCHDOG_LIMIT = 1000;
	// quiet cycles after the last result, well past the pipeline depth
	localparam int DRAIN_CYCLES = 3 * (RTH_DIV_STAGES + 3) + 10;
	// requests at the end of the run that see no idling on either side
	localparam int TAIL_ITEMS = 100;
	localparam int RANDOM_ITEMS = 650;

	// a converted pixel waiting to come out, with the pixel that caused it
	typedef struct packed {
		pix_t pixel;
		hsv_t result;
	} pending_hsv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pix_t pix = '0;
	logic hsv_valid;
	logic hsv_ready = 1'b0;
	hsv_t hsv;

	pix_t pix_pending[$];
	pending_hsv_t hsv_expected[$];
	int pix_total = 0;
	int pix_sent = 0;
	int hsv_seen = 0;
	int pix_idle = 0;
	int hsv_idle = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	rgb_to_hsv_pixel_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv)
	);

	always #5 clk = ~clk;

	// exact integer conversion of one pixel
	function automatic hsv_t predict_hsv(pix_t p);
		int b;
		int g;
		int r;
		int top;
		int bottom;
		int chroma;
		int half_deg;
		hsv_t res;
		b = p.blue;
		g = p.green;
		r = p.red;
		top = r;
		if (g > top) top = g;
		if (b > top) top = b;
		bottom = r;
		if (g < bottom) bottom = g;
		if (b < bottom) bottom = b;
		chroma = top - bottom;
		res.brightness = top[7:0];
		res.saturation = (top == 0) ? 8'd0 : 8'((255 * chroma) / top);
		if (chroma == 0) begin
			res.hue_half_degrees = 8'd0;
		end else begin
			// half degrees times chroma; red wins ties, then green
			if (top == r) begin
				half_deg = 30 * (g - b);
				if (half_deg < 0) half_deg = half_deg + 180 * chroma;
			end else if (top == g) begin
				half_deg = 60 * chroma + 30 * (b - r);
			end else begin
				half_deg = 120 * chroma + 30 * (r - g);
			end
			res.hue_half_degrees = 8'(half_deg / chroma);
		end
		return res;
	endfunction

	task automatic add_pixel(input int b, input int g, input int r);
		pix_t p;
		p.blue = b[7:0];
		p.green = g[7:0];
		p.red = r[7:0];
		pix_pending.push_back(p);
	endtask

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		error_count++;
	endtask

	// request driver with random idle bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (!pix_valid || pix_ready) begin
				if (pix_valid) begin
					hsv_expected.push_back('{pixel: pix, result: predict_hsv(pix)});
					pix_sent <= pix_sent + 1;
				end
				if (pix_idle > 0) begin
					pix_idle <= pix_idle - 1;
					pix_valid <= 1'b0;
				end else if (pix_pending.size() != 0 && pix_sent < pix_total - TAIL_ITEMS
						&& $urandom_range(0, 5) == 0) begin
					pix_idle <= $urandom_range(0, 3);
					pix_valid <= 1'b0;
				end else if (pix_pending.size() != 0) begin
					pix <= pix_pending.pop_front();
					pix_valid <= 1'b1;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and backpressure
	always @(posedge clk) begin
		pending_hsv_t want;
		if (arst_n) begin
			if (hsv_valid && hsv_ready) begin
				hsv_seen <= hsv_seen + 1;
				if (hsv_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected result h=%0d s=%0d v=%0d",
						hsv.hue_half_degrees, hsv.saturation, hsv.brightness));
				end else begin
					want = hsv_expected.pop_front();
					if (hsv.hue_half_degrees !== want.result.hue_half_degrees
							|| hsv.saturation !== want.result.saturation
							|| hsv.brightness !== want.result.brightness) begin
						report_mismatch($sformatf(
							"pixel b=%0d g=%0d r=%0d: got h=%0d s=%0d v=%0d, want h=%0d s=%0d v=%0d",
							want.pixel.blue, want.pixel.green, want.pixel.red,
							hsv.hue_half_degrees, hsv.saturation, hsv.brightness,
							want.result.hue_half_degrees, want.result.saturation,
							want.result.brightness));
					end
				end
			end
			if (hsv_idle > 0) begin
				hsv_idle <= hsv_idle - 1;
				hsv_ready <= 1'b0;
			end else if (hsv_seen < pix_total - TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
				hsv_idle <= $urandom_range(0, 3);
				hsv_ready <= 1'b0;
			end else begin
				hsv_ready <= 1'b1;
			end
		end
	end

	// hang detection
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && pix_ready) || (hsv_valid && hsv_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles = quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin
		int mode;
		int v;
		int lo;
		// black, gray and white
		add_pixel(0, 0, 0);
		add_pixel(255, 255, 255);
		add_pixel(128, 128, 128);
		// primaries
		add_pixel(0, 0, 255);
		add_pixel(0, 255, 0);
		add_pixel(255, 0, 0);
		// ties for the maximum
		add_pixel(0, 255, 255);
		add_pixel(255, 0, 255);
		add_pixel(255, 255, 0);
		add_pixel(255, 254, 255);
		// red maximum with green below blue wraps around; green above blue does not
		add_pixel(1, 0, 255);
		add_pixel(0, 1, 255);
		// smallest nonzero maximum
		add_pixel(0, 0, 1);
		add_pixel(1, 1, 0);
		add_pixel(0, 1, 1);
		// blue and green sectors on both sides, red with green above blue
		add_pixel(200, 100, 50);
		add_pixel(200, 50, 100);
		add_pixel(100, 200, 50);
		add_pixel(50, 200, 100);
		add_pixel(50, 100, 200);
		// alternating bit patterns and chroma of one
		add_pixel(170, 85, 255);
		add_pixel(85, 170, 0);
		add_pixel(254, 255, 254);

		// random pixels, weighted toward ties, grays and extremes
		repeat (RANDOM_ITEMS) begin
			mode = $urandom_range(0, 9);
			v = $urandom_range(0, 255);
			lo = $urandom_range(0, v);
			case (mode)
				0: add_pixel(v, v, v);
				1: add_pixel(lo, v, v);
				2: add_pixel(v, lo, v);
				3: add_pixel(v, v, lo);
				4: add_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 255),
					$urandom_range(0, 1) * 255);
				default: add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			endcase
		end
		pix_total = pix_pending.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pix_sent < pix_total || hsv_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/rth_pkg.sv
hdl/rth_div_pipe.sv
hdl/rgb_to_hsv_pixel_core.sv
tb/rgb_to_hsv_pixel_core_test.sv
